>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the row top-k sparsifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

`endif

>>> rtl/rtks_pkg.sv
// ----------------------------------------------------------------------------
// rtks_pkg
// Types and constants shared by the row top-k sparsifier modules.
// ----------------------------------------------------------------------------
package rtks_pkg;

   localparam int DEF_MAX_ROW   = 64;
   localparam int DEF_ELEM_BITS = 32;

   localparam int CFG_BITS = 7;
   localparam int COL_BITS = 6;

   localparam logic CFG_ROW_LENGTH = 1'b0;
   localparam logic CFG_KEEP_COUNT = 1'b1;

   localparam logic [CFG_BITS-1:0] RST_ROW_LENGTH = 7'd64;
   localparam logic [CFG_BITS-1:0] RST_KEEP_COUNT = 7'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic issue;
      logic issue_cand;
      logic emit;
      logic last;
   } ctl_type;

endpackage

>>> rtl/rtks_ram.sv
// ----------------------------------------------------------------------------
// rtks_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module rtks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rtks_ctrl.sv
// ----------------------------------------------------------------------------
// rtks_ctrl
// Row load and replay sequencer: fills the row store, then scans it once per
// column to rank each element.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtks_ctrl import rtks_pkg::*; #(
   parameter int MAX_ROW = DEF_MAX_ROW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [CFG_BITS-1:0]          row_length,
   input  logic [CFG_BITS-1:0]          keep_count,
   output logic                         busy,
   output logic                         wr_en,
   output logic [$clog2(MAX_ROW)-1:0]   wr_addr,
   output logic [$clog2(MAX_ROW)-1:0]   rd_addr,
   output logic [$clog2(MAX_ROW)-1:0]   col,
   output logic [$clog2(MAX_ROW+1)-1:0] keep,
   output ctl_type                      ctl
);

   localparam int AW = $clog2(MAX_ROW);
   localparam int CW = $clog2(MAX_ROW + 1);
   localparam logic [CFG_BITS-1:0] MAX_LEN = CFG_BITS'(MAX_ROW);

   state_type     state_ff, state_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] col_ff, col_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] keep_ff, keep_in;

   logic [CW-1:0] len_eff;
   logic [CW-1:0] count;
   logic [CW-1:0] keep_eff;
   logic          accept;
   logic          row_done;
   logic          col_last;

   always_comb begin
      if (row_length == '0) begin
         len_eff = CW'(1);
      end else if (row_length > MAX_LEN) begin
         len_eff = CW'(MAX_ROW);
      end else begin
         len_eff = CW'(row_length);
      end
   end

   assign count    = CW'(fill_ff) + CW'(1);
   assign row_done = count >= len_eff;
   assign keep_eff = (keep_count > CFG_BITS'(count)) ? count : CW'(keep_count);
   assign accept   = start && (state_ff == ST_IDLE);
   assign col_last = (CW'(col_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && row_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (step_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = col_last ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy           = state_ff != ST_IDLE;
      wr_en          = accept;
      wr_addr        = fill_ff;
      rd_addr        = (step_ff == '0) ? col_ff : AW'(step_ff - CW'(1));
      col            = col_ff;
      keep           = keep_ff;
      ctl.issue      = state_ff == ST_READ;
      ctl.issue_cand = (state_ff == ST_READ) && (step_ff == '0);
      ctl.emit       = state_ff == ST_EMIT;
      ctl.last       = (state_ff == ST_EMIT) && col_last;
   end

   always_comb begin
      fill_in  = fill_ff;
      col_in   = col_ff;
      count_in = count_ff;
      keep_in  = keep_ff;
      step_in  = '0;
      if (accept) begin
         fill_in = row_done ? '0 : AW'(count);
         if (row_done) begin
            count_in = count;
            keep_in  = keep_eff;
            col_in   = '0;
         end
      end
      if (state_ff == ST_READ) begin
         step_in = step_ff + CW'(1);
      end
      if ((state_ff == ST_EMIT) && !col_last) begin
         col_in = col_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         col_ff   <= '0;
         step_ff  <= '0;
         count_ff <= '0;
         keep_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         keep_ff  <= keep_in;
      end
   end

   `ASSERT_IMPLY(a_col_in_row, state_ff != ST_IDLE, CW'(col_ff) < count_ff)
   `ASSERT_IMPLY(a_keep_in_row, state_ff != ST_IDLE, keep_ff <= count_ff)
   `ASSERT_IMPLY(a_fill_cleared, state_ff != ST_IDLE, fill_ff == '0)

endmodule

>>> rtl/rtks_rank.sv
// ----------------------------------------------------------------------------
// rtks_rank
// Rank datapath: holds the candidate element, counts the elements that rank
// above it during the scan, and registers the result transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtks_rank import rtks_pkg::*; #(
   parameter int MAX_ROW   = DEF_MAX_ROW,
   parameter int ELEM_BITS = DEF_ELEM_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_type                      ctl,
   input  logic [$clog2(MAX_ROW)-1:0]   rd_addr,
   input  logic [$clog2(MAX_ROW)-1:0]   col,
   input  logic [$clog2(MAX_ROW+1)-1:0] keep,
   input  logic [ELEM_BITS-1:0]         rd_data,
   output logic                         rsp_valid,
   output logic signed [ELEM_BITS-1:0]  rsp_out_value,
   output logic [COL_BITS-1:0]          rsp_out_column,
   output logic                         rsp_row_end
);

   localparam int AW = $clog2(MAX_ROW);
   localparam int CW = $clog2(MAX_ROW + 1);

   logic                 rd_valid_ff;
   logic                 rd_cand_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic [ELEM_BITS-1:0] cand_ff, cand_in;
   logic [AW-1:0]        rank_ff, rank_in;
   logic                 valid_ff;
   logic [ELEM_BITS-1:0] value_ff, value_in;
   logic [COL_BITS-1:0]  column_ff;
   logic                 end_ff;

   logic above;
   logic kept;

   assign above = ($signed(rd_data) > $signed(cand_ff)) ||
                  ((rd_data == cand_ff) && (rd_idx_ff < col));
   assign kept  = CW'(rank_ff) < keep;

   always_comb begin
      cand_in  = cand_ff;
      rank_in  = rank_ff;
      value_in = kept ? cand_ff : '0;
      if (rd_valid_ff && rd_cand_ff) begin
         cand_in = rd_data;
         rank_in = '0;
      end else if (rd_valid_ff && above) begin
         rank_in = rank_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_cand_ff  <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.issue;
         rd_cand_ff  <= ctl.issue_cand;
         valid_ff    <= ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      cand_ff   <= cand_in;
      rank_ff   <= rank_in;
      value_ff  <= value_in;
      column_ff <= COL_BITS'(col);
      end_ff    <= ctl.last;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_value  = value_ff;
   assign rsp_out_column = column_ff;
   assign rsp_row_end    = end_ff;

   `ASSERT_IMPLY(a_emit_after_drain, ctl.emit, !rd_valid_ff)
   `ASSERT_IMPLY(a_last_is_emit, ctl.last, ctl.emit)

endmodule

>>> rtl/row_top_k_sparsify_unit.sv
// ----------------------------------------------------------------------------
// row_top_k_sparsify_unit
// Stores one row of signed elements and replays it in column order, keeping
// the keep_count largest elements and zeroing the rest; ties go to the lower
// column.
// ----------------------------------------------------------------------------
// Elements are accepted one per cycle while busy is low. The element that
// completes a row starts the replay: for a row of n elements the block scans
// the row store once per column through its single read port, and busy stays
// high until the last result has been issued. Each result appears for one
// cycle with rsp_valid high and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module row_top_k_sparsify_unit import rtks_pkg::*; #(
   parameter int MAX_ROW   = DEF_MAX_ROW,
   parameter int ELEM_BITS = DEF_ELEM_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [ELEM_BITS-1:0] req_element_value,
   output logic                        rsp_valid,
   output logic signed [ELEM_BITS-1:0] rsp_out_value,
   output logic [COL_BITS-1:0]         rsp_out_column,
   output logic                        rsp_row_end,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int AW = $clog2(MAX_ROW);
   localparam int CW = $clog2(MAX_ROW + 1);

   logic [CFG_BITS-1:0] row_length_ff, row_length_in;
   logic [CFG_BITS-1:0] keep_count_ff, keep_count_in;
   logic                csr_write;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        col;
   logic [CW-1:0]        keep;
   logic [ELEM_BITS-1:0] rd_data;
   ctl_type              ctl;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      row_length_in = row_length_ff;
      keep_count_in = keep_count_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CFG_ROW_LENGTH: row_length_in = pwdata[CFG_BITS-1:0];
            CFG_KEEP_COUNT: keep_count_in = pwdata[CFG_BITS-1:0];
            default:        row_length_in = row_length_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CFG_ROW_LENGTH: prdata = {{(32-CFG_BITS){1'b0}}, row_length_ff};
         CFG_KEEP_COUNT: prdata = {{(32-CFG_BITS){1'b0}}, keep_count_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= RST_ROW_LENGTH;
         keep_count_ff <= RST_KEEP_COUNT;
      end else begin
         row_length_ff <= row_length_in;
         keep_count_ff <= keep_count_in;
      end
   end

   rtks_ctrl #(
      .MAX_ROW (MAX_ROW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .row_length (row_length_ff),
      .keep_count (keep_count_ff),
      .busy       (busy),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .col        (col),
      .keep       (keep),
      .ctl        (ctl)
   );

   rtks_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (MAX_ROW)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rtks_rank #(
      .MAX_ROW   (MAX_ROW),
      .ELEM_BITS (ELEM_BITS)
   ) u_rank (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .rd_addr        (rd_addr),
      .col            (col),
      .keep           (keep),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_column (rsp_out_column),
      .rsp_row_end    (rsp_row_end)
   );

endmodule

>>> sim/row_top_k_sparsify_unit_tb.sv
// ----------------------------------------------------------------------------
// row_top_k_sparsify_unit_tb
// Self-checking testbench for the row top-k sparsifier. A queue of pending
// operations (elements, register writes and drain points) feeds a clocked
// driver. The driver mirrors every accepted element into a software copy of
// the row and predicts the replayed row. A clocked monitor compares each
// result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module row_top_k_sparsify_unit_tb import rtks_pkg::*; ();

   localparam int ELEM_W        = DEF_ELEM_BITS;
   localparam int SETTLE_CYCLES = 12;
   localparam int TAIL_CYCLES   = 100;
   localparam int STALL_LIMIT   = 5000;
   localparam int ITEM_TARGET   = 220;
   localparam int CALM_FROM     = 180;

   typedef enum logic [1:0] {OP_ELEM, OP_WRITE, OP_SYNC} op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      logic signed [ELEM_W-1:0]  value;
      logic                      reg_idx;
      logic [31:0]               data;
      logic                      quiet;
   } pend_op_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0]  value;
      logic [COL_BITS-1:0]       column;
      logic                      last;
   } replay_elem_type;

   typedef enum logic [2:0] {
      DRV_FETCH, DRV_DRAIN, DRV_SETTLE, DRV_SETUP, DRV_ACCESS
   } drv_state_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [ELEM_W-1:0]  req_element_value = '0;
   logic                      rsp_valid;
   logic signed [ELEM_W-1:0]  rsp_out_value;
   logic [COL_BITS-1:0]       rsp_out_column;
   logic                      rsp_row_end;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [2:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   pend_op_type               pending_q [$];
   replay_elem_type           replay_q [$];

   logic signed [ELEM_W-1:0]  row_buf [DEF_MAX_ROW];
   int                        row_fill = 0;
   logic [CFG_BITS-1:0]       cfg_row_length = RST_ROW_LENGTH;
   logic [CFG_BITS-1:0]       cfg_keep_count = RST_KEEP_COUNT;

   int                        gen_fill = 0;
   logic [CFG_BITS-1:0]       gen_len = RST_ROW_LENGTH;
   int                        elem_total = 0;

   drv_state_type             drv_state = DRV_FETCH;
   pend_op_type               cur_op;
   int                        gap_left = 0;
   int                        settle_left = 0;
   logic                      stim_done = 1'b0;
   int                        fail_count = 0;
   int                        stall_cycles = 0;

   row_top_k_sparsify_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_column    (rsp_out_column),
      .rsp_row_end       (rsp_row_end),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int eff_length(input logic [CFG_BITS-1:0] raw);
      if (raw == 0) begin
         return 1;
      end
      if (raw > DEF_MAX_ROW) begin
         return DEF_MAX_ROW;
      end
      return int'(raw);
   endfunction

   // Stores one element and, when it completes the row, predicts the replay.
   task automatic take_element(input logic signed [ELEM_W-1:0] v);
      int cnt;
      int keep;
      int rank;
      replay_elem_type e;
      if (row_fill >= DEF_MAX_ROW) begin
         row_fill = DEF_MAX_ROW - 1;
      end
      row_buf[row_fill] = v;
      cnt = row_fill + 1;
      if (cnt < eff_length(cfg_row_length)) begin
         row_fill = cnt;
      end else begin
         keep = (int'(cfg_keep_count) > cnt) ? cnt : int'(cfg_keep_count);
         for (int c = 0; c < cnt; c++) begin
            rank = 0;
            for (int d = 0; d < cnt; d++) begin
               if (d != c && (row_buf[d] > row_buf[c] ||
                              (row_buf[d] == row_buf[c] && d < c))) begin
                  rank++;
               end
            end
            e.value  = (rank < keep) ? row_buf[c] : '0;
            e.column = COL_BITS'(c);
            e.last   = (c == cnt - 1);
            replay_q.push_back(e);
         end
         row_fill = 0;
      end
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom_range(0, 4) - 2;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic add_elem(input logic signed [ELEM_W-1:0] v, input logic quiet);
      pend_op_type op;
      op = '0;
      op.kind = OP_ELEM;
      op.value = v;
      op.quiet = quiet || (elem_total >= CALM_FROM);
      pending_q.push_back(op);
      elem_total++;
      if (gen_fill >= DEF_MAX_ROW) begin
         gen_fill = DEF_MAX_ROW - 1;
      end
      if (gen_fill + 1 < eff_length(gen_len)) begin
         gen_fill++;
      end else begin
         gen_fill = 0;
      end
   endtask

   task automatic add_write(input logic idx, input logic [CFG_BITS-1:0] val);
      pend_op_type op;
      op = '0;
      op.kind = OP_WRITE;
      op.reg_idx = idx;
      op.data = ($urandom() & 32'hFFFF_FF80) | 32'(val);
      pending_q.push_back(op);
      if (idx == CFG_ROW_LENGTH) begin
         gen_len = val;
      end
   endtask

   task automatic add_sync();
      pend_op_type op;
      op = '0;
      op.kind = OP_SYNC;
      pending_q.push_back(op);
   endtask

   task automatic add_row(input logic quiet);
      do begin
         add_elem(rand_elem(), quiet);
      end while (gen_fill != 0);
   endtask

   task automatic build_stimulus();
      int phase_idx;
      int eff;
      int rows;
      logic [CFG_BITS-1:0] len;
      logic [CFG_BITS-1:0] keep;
      logic quiet;
      phase_idx = 0;

      add_write(CFG_ROW_LENGTH, 7'd4);
      add_write(CFG_KEEP_COUNT, 7'd2);
      add_elem(32'h7FFF_FFFF, 1'b0);
      add_elem(32'h8000_0000, 1'b0);
      add_elem(-1, 1'b0);
      add_elem(0, 1'b0);
      // Equal values: the lowest column wins.
      add_write(CFG_ROW_LENGTH, 7'd3);
      add_write(CFG_KEEP_COUNT, 7'd1);
      repeat (3) add_elem(5, 1'b0);
      // A zero length acts as one; keep nothing, then keep more than the row.
      add_write(CFG_ROW_LENGTH, 7'd0);
      add_write(CFG_KEEP_COUNT, 7'd0);
      add_elem(32'h7FFF_FFFF, 1'b0);
      add_write(CFG_KEEP_COUNT, 7'd127);
      add_elem(32'h8000_0000, 1'b0);
      add_write(CFG_ROW_LENGTH, 7'd2);
      add_write(CFG_KEEP_COUNT, 7'd1);
      add_elem(32'h8000_0000, 1'b0);
      add_elem(32'h8000_0000, 1'b0);
      add_write(CFG_ROW_LENGTH, 7'd3);
      add_write(CFG_KEEP_COUNT, 7'd3);
      add_elem(-1, 1'b0);
      add_elem(32'h7FFF_FFFF, 1'b0);
      add_elem(32'h8000_0000, 1'b0);
      // The length drops below the fill level in the middle of a row.
      add_write(CFG_ROW_LENGTH, 7'd5);
      add_write(CFG_KEEP_COUNT, 7'd2);
      add_elem(-7, 1'b0);
      add_elem(9, 1'b0);
      add_elem(9, 1'b0);
      add_write(CFG_ROW_LENGTH, 7'd2);
      add_elem(3, 1'b0);
      add_sync();

      while (elem_total < ITEM_TARGET) begin
         if (phase_idx == 0) begin
            len = 7'd64;
         end else if (phase_idx == 2) begin
            len = 7'($urandom_range(65, 127));
         end else begin
            case ($urandom_range(0, 9))
               0: len = 7'd0;
               1: len = 7'($urandom_range(9, 24));
               2: len = 7'($urandom_range(2, 4));
               default: len = 7'($urandom_range(1, 8));
            endcase
         end
         eff = eff_length(len);
         case ($urandom_range(0, 9))
            0: keep = 7'd0;
            1: keep = 7'd127;
            2: keep = 7'(eff + $urandom_range(1, 3));
            3: keep = 7'(eff);
            default: keep = 7'($urandom_range(0, eff));
         endcase
         add_write(CFG_ROW_LENGTH, len);
         add_write(CFG_KEEP_COUNT, keep);
         quiet = ($urandom_range(0, 3) == 0);
         rows = (eff > 24) ? 1 : $urandom_range(1, 4);
         repeat (rows) add_row(quiet);
         if (eff > 1 && eff <= 24 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, eff - 1)) add_elem(rand_elem(), quiet);
         end
         if ($urandom_range(0, 5) == 0) begin
            add_sync();
         end
         phase_idx++;
      end
   endtask

   always @(posedge clock) begin
      logic nxt_start;
      nxt_start = start;
      if (reset) begin
         nxt_start = 1'b0;
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         drv_state = DRV_FETCH;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            take_element(req_element_value);
            nxt_start = 1'b0;
         end
         if (!nxt_start) begin
            case (drv_state)
               DRV_FETCH: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else if (pending_q.size() > 0) begin
                     cur_op = pending_q.pop_front();
                     if (cur_op.kind == OP_ELEM) begin
                        req_element_value <= cur_op.value;
                        nxt_start = 1'b1;
                        if (!cur_op.quiet && $urandom_range(0, 3) == 0) begin
                           gap_left = $urandom_range(1, 17);
                        end
                     end else begin
                        drv_state = DRV_DRAIN;
                     end
                  end
               end
               DRV_DRAIN: begin
                  if (replay_q.size() == 0 && !busy) begin
                     settle_left = SETTLE_CYCLES;
                     drv_state = DRV_SETTLE;
                  end
               end
               DRV_SETTLE: begin
                  if (settle_left > 0) begin
                     settle_left--;
                  end else if (cur_op.kind == OP_WRITE) begin
                     psel <= 1'b1;
                     pwrite <= 1'b1;
                     paddr <= {cur_op.reg_idx, 2'b00};
                     pwdata <= cur_op.data;
                     drv_state = DRV_SETUP;
                  end else begin
                     drv_state = DRV_FETCH;
                  end
               end
               DRV_SETUP: begin
                  penable <= 1'b1;
                  drv_state = DRV_ACCESS;
               end
               DRV_ACCESS: begin
                  if (psel && penable && pwrite && pready) begin
                     if (cur_op.reg_idx == CFG_ROW_LENGTH) begin
                        cfg_row_length = cur_op.data[CFG_BITS-1:0];
                     end else begin
                        cfg_keep_count = cur_op.data[CFG_BITS-1:0];
                     end
                     psel <= 1'b0;
                     penable <= 1'b0;
                     pwrite <= 1'b0;
                     drv_state = DRV_FETCH;
                  end
               end
               default: drv_state = DRV_FETCH;
            endcase
         end
      end
      start <= nxt_start;
      stim_done <= (pending_q.size() == 0) && (drv_state == DRV_FETCH) && !nxt_start;
   end

   always @(posedge clock) begin
      replay_elem_type exp_e;
      if (!reset && rsp_valid) begin
         if (replay_q.size() == 0) begin
            $display("%0t: result transfer with nothing expected: column %0d value %0d",
                     $time, rsp_out_column, rsp_out_value);
            fail_count++;
         end else begin
            exp_e = replay_q.pop_front();
            if (rsp_out_value !== exp_e.value) begin
               $display("%0t: out_value mismatch: expected %0d actual %0d",
                        $time, exp_e.value, rsp_out_value);
               fail_count++;
            end
            if (rsp_out_column !== exp_e.column) begin
               $display("%0t: out_column mismatch: expected %0d actual %0d",
                        $time, exp_e.column, rsp_out_column);
               fail_count++;
            end
            if (rsp_row_end !== exp_e.last) begin
               $display("%0t: row_end mismatch: expected %0b actual %0b",
                        $time, exp_e.last, rsp_row_end);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_valid || (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      build_stimulus();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do begin
         @(posedge clock);
      end while (!(stim_done && replay_q.size() == 0));
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
